// ===== hdl/positional_array_insert_delete_assert.svh =====
// ----------------------------------------------------------------------------
// positional_array_insert_delete assertion macros
// Clocked assertion wrappers used by the positional array top level.
// They expect signals named clk and arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PAI_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PAI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PAI_ASSERT_IMPL(lbl, ante, cons, msg)
`define PAI_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/posarr_pkg.sv =====
// ----------------------------------------------------------------------------
// posarr_pkg
// Shared types and constants for the positional array with insert/delete.
// ----------------------------------------------------------------------------
package posarr_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int POS_W        = 8;
	localparam int DATA_W       = 32;
	localparam int COUNT_W      = 8;

	// operation selector
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	// result status
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic             ins;   // shift up above idx, load at idx
		logic             del;   // shift down from idx upward
		logic [POS_W-1:0] idx;   // 0-based target position
	} cell_cmd_t;

endpackage

// ===== hdl/posarr_cell.sv =====
// ----------------------------------------------------------------------------
// posarr_cell
// One element of the array row. Holds, loads, or takes its neighbor's data.
// ----------------------------------------------------------------------------
module posarr_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  posarr_pkg::cell_cmd_t             cmd,
	input  logic [posarr_pkg::DATA_W-1:0]     value,
	input  logic [posarr_pkg::DATA_W-1:0]     lower_data,   // cell IDX-1
	input  logic [posarr_pkg::DATA_W-1:0]     upper_data,   // cell IDX+1
	output logic [posarr_pkg::DATA_W-1:0]     data_q
);

	localparam logic [posarr_pkg::POS_W-1:0] MY_IDX = posarr_pkg::POS_W'(IDX);

	logic [posarr_pkg::DATA_W-1:0] data_d;

	// local decision: insert opens a gap at idx, delete closes it
	always_comb begin
		data_d = data_q;
		if (cmd.ins) begin
			if (MY_IDX > cmd.idx) begin
				data_d = lower_data;
			end else if (MY_IDX == cmd.idx) begin
				data_d = value;
			end
		end else if (cmd.del) begin
			if (MY_IDX >= cmd.idx) begin
				data_d = upper_data;
			end
		end
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

// ===== hdl/posarr_ctrl.sv =====
// ----------------------------------------------------------------------------
// posarr_ctrl
// Decodes an operation, checks its position, keeps the element count and
// issues the shift command to the cell row.
// ----------------------------------------------------------------------------
module posarr_ctrl #(
	parameter int CAPACITY = posarr_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  posarr_pkg::op_t                   op,
	input  logic [posarr_pkg::POS_W-1:0]      pos,
	output posarr_pkg::cell_cmd_t             cmd,
	output posarr_pkg::status_t               status,
	output logic [posarr_pkg::COUNT_W-1:0]    count_next,
	output logic [posarr_pkg::COUNT_W-1:0]    count_q
);

	localparam logic [posarr_pkg::COUNT_W-1:0] CAP_CNT = posarr_pkg::COUNT_W'(CAPACITY);

	logic pos_zero;
	logic ins_pos_ok;
	logic acc_pos_ok;
	logic full;
	logic do_ins;
	logic do_del;

	// position checks: insert allows count+1, delete/read allow count
	assign pos_zero   = (pos == '0);
	assign ins_pos_ok = !pos_zero && ({1'b0, pos} <= ({1'b0, count_q} + 9'd1));
	assign acc_pos_ok = !pos_zero && (pos <= count_q);
	assign full       = (count_q >= CAP_CNT);

	// status and action decode
	always_comb begin
		status = posarr_pkg::ST_OK;
		do_ins = 1'b0;
		do_del = 1'b0;
		case (op)
			posarr_pkg::OP_CLEAR: begin
				status = posarr_pkg::ST_OK;
			end
			posarr_pkg::OP_INSERT: begin
				if (!ins_pos_ok) begin
					status = posarr_pkg::ST_BAD_POS;
				end else if (full) begin
					status = posarr_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			posarr_pkg::OP_DELETE: begin
				if (!acc_pos_ok) begin
					status = posarr_pkg::ST_BAD_POS;
				end else begin
					do_del = 1'b1;
				end
			end
			posarr_pkg::OP_READ: begin
				if (!acc_pos_ok) begin
					status = posarr_pkg::ST_BAD_POS;
				end
			end
			default: begin
				status = posarr_pkg::ST_OK;
			end
		endcase
	end

	// count after this operation
	always_comb begin
		if (op == posarr_pkg::OP_CLEAR) begin
			count_next = '0;
		end else if (do_ins) begin
			count_next = count_q + 8'd1;
		end else if (do_del) begin
			count_next = count_q - 8'd1;
		end else begin
			count_next = count_q;
		end
	end

	// cell command, only on an accepted transaction
	assign cmd.ins = fire && do_ins;
	assign cmd.del = fire && do_del;
	assign cmd.idx = pos - 8'd1;

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_next;
		end
	end

endmodule

// ===== hdl/positional_array_insert_delete.sv =====
// ----------------------------------------------------------------------------
// positional_array_insert_delete
// A transaction's result is in the output register in the cycle after it is
// accepted. Throughput: one transaction per cycle while the result side takes
// data; the row of cells shifts or loads as the transaction is accepted.
// Reset clears the count and the output valid; cell contents stay undefined.
// ----------------------------------------------------------------------------
module positional_array_insert_delete #(
	parameter int CAPACITY = posarr_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [7:0] position, [39:8] value
	input  logic [1:0]  s_axis_tuser,   // [1:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] read_value, [39:32] count
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	`include "positional_array_insert_delete_assert.svh"

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [posarr_pkg::COUNT_W-1:0] CAP_CNT = posarr_pkg::COUNT_W'(CAPACITY);

	logic                               in_fire;
	posarr_pkg::op_t                    op;
	logic [posarr_pkg::POS_W-1:0]       pos;
	logic [posarr_pkg::DATA_W-1:0]      value;
	posarr_pkg::cell_cmd_t              cmd;
	posarr_pkg::status_t                status;
	logic [posarr_pkg::COUNT_W-1:0]     count_next;
	logic [posarr_pkg::COUNT_W-1:0]     count;
	logic [posarr_pkg::DATA_W-1:0]      cell_data [CAPACITY];
	logic [posarr_pkg::DATA_W-1:0]      rd_value;

	logic                               out_valid_q;
	posarr_pkg::status_t                status_q;
	logic [posarr_pkg::DATA_W-1:0]      rd_q;
	logic [posarr_pkg::COUNT_W-1:0]     count_out_q;

	// input unpacking and handshake
	assign op            = posarr_pkg::op_t'(s_axis_tuser);
	assign pos           = s_axis_tdata[7:0];
	assign value         = s_axis_tdata[39:8];
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	posarr_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (in_fire),
		.op         (op),
		.pos        (pos),
		.cmd        (cmd),
		.status     (status),
		.count_next (count_next),
		.count_q    (count)
	);

	// row of cells, each linked to its neighbors; the first sees zero below, the last sees itself above
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [posarr_pkg::DATA_W-1:0] lower;
		logic [posarr_pkg::DATA_W-1:0] upper;
		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_mid_lo
			assign lower = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper = cell_data[i];
		end else begin : g_mid_hi
			assign upper = cell_data[i+1];
		end
		posarr_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.value      (value),
			.lower_data (lower),
			.upper_data (upper),
			.data_q     (cell_data[i])
		);
	end

	// read select, zero unless a successful read
	always_comb begin
		rd_value = '0;
		if (op == posarr_pkg::OP_READ && status == posarr_pkg::ST_OK) begin
			rd_value = cell_data[cmd.idx[IDX_W-1:0]];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_q    <= status;
			rd_q        <= rd_value;
			count_out_q <= count_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {count_out_q, rd_q};
	assign m_axis_tuser  = status_q;

	// checks
	`PAI_ASSERT_IMPL(a_count_bound, 1'b1, count <= CAP_CNT, "count exceeds capacity")
	`PAI_ASSERT_NEXT(a_ins_count, in_fire && cmd.ins, count == $past(count) + 8'd1, "insert count")
	`PAI_ASSERT_NEXT(a_del_count, in_fire && cmd.del, count == $past(count) - 8'd1, "delete count")
	`PAI_ASSERT_IMPL(a_full_flag, in_fire && status == posarr_pkg::ST_FULL, count == CAP_CNT, "full flag")

endmodule
